### sv/pfnt_pkg.sv
// Package of shared types, constants and a helper function for the pose fusion block.
`default_nettype none
package pfnt_pkg;
    localparam int BufferDepth = 15;
    localparam int IdxW        = $clog2(BufferDepth);
    localparam int CntW        = $clog2(BufferDepth + 1);
    localparam int StampW      = 63;
    localparam int PosW        = 32;
    localparam int QuatW       = 16;
    localparam int QueueDepth  = 2;

    typedef enum logic [1:0] {
        MODE_LIDAR    = 2'd0,
        MODE_GNSS     = 2'd1,
        MODE_FUSED    = 2'd2,
        MODE_DEGEN    = 2'd3
    } mode_t;

    // Sample as captured by the front end.
    typedef struct packed {
        logic                    source;
        logic [StampW-1:0]       stamp;
        logic signed [PosW-1:0]  px;
        logic signed [PosW-1:0]  py;
        logic signed [PosW-1:0]  pz;
        logic signed [QuatW-1:0] qw;
        logic signed [QuatW-1:0] qx;
        logic signed [QuatW-1:0] qy;
        logic signed [QuatW-1:0] qz;
    } sample_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [PosW-1:0]  fx;
        logic signed [PosW-1:0]  fy;
        logic signed [PosW-1:0]  fz;
        logic signed [QuatW-1:0] qw;
        logic signed [QuatW-1:0] qx;
        logic signed [QuatW-1:0] qy;
        logic signed [QuatW-1:0] qz;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_WAIT,
        ST_SQUARE,
        ST_DIV,
        ST_ROOT,
        ST_NEXT,
        ST_OUT
    } be_state_t;

    function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] a,
                                                 input logic [CntW-1:0] b);
        logic [IdxW+1:0] s;
        s = {2'b00, a} + {{(IdxW+2-CntW){1'b0}}, b};
        if (s >= (IdxW+2)'(BufferDepth))
            s = s - (IdxW+2)'(BufferDepth);
        return s[IdxW-1:0];
    endfunction
endpackage
`default_nettype wire

### sv/pose_fusion_nearest_timestamp.sv
// Top level of the nearest-timestamp pose fusion block.
// Usage:
//   The input channel (in_valid/in_ready) carries one pose sample per beat,
//   from lidar (source 0) or gnss (source 1). The output channel
//   (out_valid/out_ready) carries exactly one fused pose beat per input beat,
//   in input order.
//   A two-entry queue at the front takes up to two beats while the back end
//   works; a beat is registered in the queue before the back end picks it up.
//   The back end handles one sample at a time. It walks the gnss ring, one
//   RAM read per cycle, then for a fused pose squares the quaternion sum and,
//   for each of the four components, runs a restoring divide, a root search
//   and a write-back step. Lidar with an empty ring, gnss pass-through and a
//   degenerate fused pose go to the output without the divide and root steps.
//   The back end takes no new sample until the current result has been taken.
//   Reset clears the lidar valid flag, the gnss fill count and ring pointer;
//   the ring RAM itself is not cleared since an entry is only read after it
//   has been written.
//   When the receiver stalls, the result holds on the output ports and the
//   back end waits; the front queue fills and then in_ready drops.
`default_nettype none
module pose_fusion_nearest_timestamp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                source,
    input  wire logic [62:0]         stamp_ns,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  pos_z,
    input  wire logic signed [15:0]  quat_w,
    input  wire logic signed [15:0]  quat_x,
    input  wire logic signed [15:0]  quat_y,
    input  wire logic signed [15:0]  quat_z,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               mode,
    output logic signed [31:0]       fused_x,
    output logic signed [31:0]       fused_y,
    output logic signed [31:0]       fused_z,
    output logic signed [15:0]       fused_qw,
    output logic signed [15:0]       fused_qx,
    output logic signed [15:0]       fused_qy,
    output logic signed [15:0]       fused_qz
);
    import pfnt_pkg::*;

    sample_t in_sample, q_sample;
    result_t res;
    logic    q_valid, q_ready;

    assign in_sample = '{source, stamp_ns, pos_x, pos_y, pos_z,
                         quat_w, quat_x, quat_y, quat_z};

    pfnt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_sample (in_sample),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_sample  (q_sample)
    );

    pfnt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_sample   (q_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (res)
    );

    assign mode     = res.mode;
    assign fused_x  = res.fx;
    assign fused_y  = res.fy;
    assign fused_z  = res.fz;
    assign fused_qw = res.qw;
    assign fused_qx = res.qx;
    assign fused_qy = res.qy;
    assign fused_qz = res.qz;
endmodule
`default_nettype wire

### sv/pfnt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pfnt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/pfnt_front.sv
// Front end: accepts input beats and pushes them into a short queue.
`default_nettype none
module pfnt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pfnt_pkg::sample_t in_sample,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output pfnt_pkg::sample_t      q_sample
);
    import pfnt_pkg::*;

    sample_t                  slot_reg [QueueDepth];
    logic [$clog2(QueueDepth)-1:0] wp_reg, rp_reg, wp_next, rp_next;
    logic [$clog2(QueueDepth):0]   cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready = (cnt_reg != ($clog2(QueueDepth)+1)'(QueueDepth));
    assign q_valid  = (cnt_reg != '0);
    assign q_sample = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop  ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {{$clog2(QueueDepth){1'b0}}, push}
                           - {{$clog2(QueueDepth){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= in_sample;
        end
    end
endmodule
`default_nettype wire

### sv/pfnt_back.sv
// Back end: stores samples, searches the gnss ring and fuses the pose.
`default_nettype none
module pfnt_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire pfnt_pkg::sample_t q_sample,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pfnt_pkg::result_t      out_result
);
    import pfnt_pkg::*;

    localparam int GW = StampW + 3 * PosW + 4 * QuatW;
    localparam int SW = QuatW + 1;      // quaternion sum
    localparam int NW = 2 * SW + 2;     // sum of four squares
    localparam int TW = 2 * SW + 30;    // scaled square / n2
    localparam int RW = 15;             // root result bits

    be_state_t state_reg, state_next;

    logic                    lvalid_reg;
    logic [StampW-1:0]       lstamp_reg;
    logic signed [PosW-1:0]  lpos_reg [3];
    logic signed [QuatW-1:0] lq_reg [4];
    logic [CntW-1:0]         gcnt_reg;
    logic [IdxW-1:0]         gold_reg;
    logic [IdxW-1:0]         newest_reg;

    logic                    ram_we;
    logic [IdxW-1:0]         ram_waddr, ram_raddr;
    logic [GW-1:0]           ram_wdata, ram_rdata;

    logic [CntW-1:0]         iter_reg;
    logic [IdxW-1:0]         best_reg;
    logic [StampW-1:0]       bdiff_reg;
    logic                    search_rd_reg;
    logic [IdxW-1:0]         rd_idx_reg;
    logic [CntW-1:0]         rd_i_reg;

    logic signed [SW-1:0]    s_reg [4];
    logic [NW-1:0]           n2_reg;
    logic [1:0]              k_reg;
    logic [2:0]              sq_cnt_reg;
    logic [TW-1:0]           num_reg, rem_reg;
    logic [TW-1:0]           quo_reg;
    logic [6:0]              div_cnt_reg;
    logic [RW-1:0]           q_root_reg;
    logic [RW-1:0]           bit_reg;
    result_t                 res_reg;

    function automatic logic [2*SW-1:0] mag_sq_next(input logic signed [SW-1:0] s);
        logic [SW-1:0] m;
        m = s[SW-1] ? SW'(-s) : SW'(s);
        return m * m;
    endfunction

    pfnt_ram #(.Width(GW), .Depth(BufferDepth)) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Unpack ring entry.
    logic [StampW-1:0]       g_stamp;
    logic signed [PosW-1:0]  g_pos [3];
    logic signed [QuatW-1:0] g_q [4];
    assign g_stamp  = ram_rdata[GW-1 -: StampW];
    assign g_pos[0] = ram_rdata[4*QuatW+3*PosW-1 -: PosW];
    assign g_pos[1] = ram_rdata[4*QuatW+2*PosW-1 -: PosW];
    assign g_pos[2] = ram_rdata[4*QuatW+PosW-1 -: PosW];
    assign g_q[0]   = ram_rdata[4*QuatW-1 -: QuatW];
    assign g_q[1]   = ram_rdata[3*QuatW-1 -: QuatW];
    assign g_q[2]   = ram_rdata[2*QuatW-1 -: QuatW];
    assign g_q[3]   = ram_rdata[QuatW-1 -: QuatW];

    logic gnss_in, accept;
    logic [IdxW-1:0] wslot;
    assign gnss_in   = q_sample.source;
    assign accept    = q_valid && q_ready;
    assign wslot     = (gcnt_reg < CntW'(BufferDepth)) ? ring_add(gold_reg, gcnt_reg)
                                                        : gold_reg;
    assign ram_we    = accept && gnss_in;
    assign ram_waddr = wslot;
    assign ram_wdata = {q_sample.stamp, q_sample.px, q_sample.py, q_sample.pz,
                        q_sample.qw, q_sample.qx, q_sample.qy, q_sample.qz};
    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_result = res_reg;

    // Read address: search walks the ring, then the chosen entry.
    logic [IdxW-1:0] search_idx;
    assign search_idx = ring_add(gold_reg, iter_reg);
    always_comb
    begin
        unique case (state_reg)
            ST_SEARCH: ram_raddr = search_idx;
            default:   ram_raddr = best_reg;
        endcase
    end

    logic [StampW-1:0] cur_diff;
    assign cur_diff = (g_stamp > lstamp_reg) ? g_stamp - lstamp_reg : lstamp_reg - g_stamp;

    logic search_done;
    assign search_done = (iter_reg == gcnt_reg);

    // Shared square of the current quaternion component.
    logic signed [SW-1:0] s_cur;
    logic [SW-1:0]        mag_cur;
    logic [2*SW-1:0]      sq_cur;
    assign s_cur   = s_reg[k_reg];
    assign mag_cur = s_cur[SW-1] ? SW'(-s_cur) : SW'(s_cur);
    assign sq_cur  = mag_cur * mag_cur;

    logic [RW-1:0]   cand;
    logic [RW:0]     dval;
    logic [2*RW+1:0] dsq;
    assign cand = q_root_reg | bit_reg;
    assign dval = {cand, 1'b0} - (RW+1)'(1);
    assign dsq  = dval * dval;

    logic [TW:0] rem_sh;
    assign rem_sh = {rem_reg, num_reg[TW-1]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_SEARCH;
            ST_SEARCH: if (search_done && !search_rd_reg) state_next = ST_READ;
            ST_READ:   state_next = ST_WAIT;
            ST_WAIT:   state_next = (!lvalid_reg || gcnt_reg == '0) ? ST_OUT : ST_SQUARE;
            ST_SQUARE: if (sq_cnt_reg == 3'd4)
                           state_next = (n2_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:    if (div_cnt_reg == 7'(TW)) state_next = ST_ROOT;
            ST_ROOT:   if (bit_reg == '0) state_next = ST_NEXT;
            ST_NEXT:   state_next = (k_reg == 2'd3) ? ST_OUT : ST_DIV;
            ST_OUT:    if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvalid_reg    <= 1'b0;
            gcnt_reg      <= '0;
            gold_reg      <= '0;
            search_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (!gnss_in)
                begin
                    lvalid_reg <= 1'b1;
                end
                else if (gcnt_reg < CntW'(BufferDepth))
                begin
                    gcnt_reg <= gcnt_reg + CntW'(1);
                end
                else
                begin
                    gold_reg <= ring_add(gold_reg, CntW'(1));
                end
            end
            search_rd_reg <= (state_reg == ST_SEARCH) && !search_done;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!gnss_in)
                    begin
                        lstamp_reg <= q_sample.stamp;
                        lpos_reg[0] <= q_sample.px;
                        lpos_reg[1] <= q_sample.py;
                        lpos_reg[2] <= q_sample.pz;
                        lq_reg[0] <= q_sample.qw;
                        lq_reg[1] <= q_sample.qx;
                        lq_reg[2] <= q_sample.qy;
                        lq_reg[3] <= q_sample.qz;
                    end
                    else
                    begin
                        newest_reg <= wslot;
                    end
                end
                iter_reg <= '0;
            end
            ST_SEARCH:
            begin
                if (!search_done)
                begin
                    iter_reg   <= iter_reg + CntW'(1);
                end
                rd_idx_reg <= search_idx;
                rd_i_reg   <= iter_reg;
                if (search_rd_reg && (rd_i_reg == '0 || cur_diff < bdiff_reg))
                begin
                    bdiff_reg <= cur_diff;
                    best_reg  <= rd_idx_reg;
                end
                if (search_done && !search_rd_reg && !lvalid_reg)
                begin
                    best_reg <= newest_reg;
                end
            end
            ST_WAIT:
            begin
                if (!lvalid_reg)
                begin
                    res_reg <= '{MODE_GNSS, g_pos[0], g_pos[1], g_pos[2],
                                 g_q[0], g_q[1], g_q[2], g_q[3]};
                end
                else if (gcnt_reg == '0)
                begin
                    res_reg <= '{MODE_LIDAR, lpos_reg[0], lpos_reg[1], lpos_reg[2],
                                 lq_reg[0], lq_reg[1], lq_reg[2], lq_reg[3]};
                end
                else
                begin
                    res_reg.mode <= MODE_FUSED;
                    res_reg.fx <= PosW'(({lpos_reg[0][PosW-1], lpos_reg[0]}
                                       + {g_pos[0][PosW-1], g_pos[0]}) >>> 1);
                    res_reg.fy <= PosW'(({lpos_reg[1][PosW-1], lpos_reg[1]}
                                       + {g_pos[1][PosW-1], g_pos[1]}) >>> 1);
                    res_reg.fz <= PosW'(({lpos_reg[2][PosW-1], lpos_reg[2]}
                                       + {g_pos[2][PosW-1], g_pos[2]}) >>> 1);
                    for (int k = 0; k < 4; k++)
                    begin
                        s_reg[k] <= SW'(lq_reg[k]) + SW'(g_q[k]);
                    end
                end
                k_reg      <= '0;
                sq_cnt_reg <= '0;
                n2_reg     <= '0;
            end
            ST_SQUARE:
            begin
                if (sq_cnt_reg != 3'd4)
                begin
                    n2_reg     <= n2_reg + NW'(sq_cur);
                    k_reg      <= k_reg + 2'd1;
                    sq_cnt_reg <= sq_cnt_reg + 3'd1;
                end
                else
                begin
                    if (n2_reg == '0)
                    begin
                        res_reg.mode <= MODE_DEGEN;
                        res_reg.qw <= '0;
                        res_reg.qx <= '0;
                        res_reg.qy <= '0;
                        res_reg.qz <= '0;
                    end
                    num_reg     <= TW'(sq_cur) << 30;
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    div_cnt_reg <= '0;
                end
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit a cycle.
                if (div_cnt_reg != 7'(TW))
                begin
                    num_reg     <= num_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 7'd1;
                    if (rem_sh >= (TW+1)'(n2_reg))
                    begin
                        rem_reg <= TW'(rem_sh - (TW+1)'(n2_reg));
                        quo_reg <= {quo_reg[TW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[TW-1:0];
                        quo_reg <= {quo_reg[TW-2:0], 1'b0};
                    end
                end
                else
                begin
                    q_root_reg <= '0;
                    bit_reg    <= RW'(16384);
                end
            end
            ST_ROOT:
            begin
                if (bit_reg != '0)
                begin
                    if (cand <= RW'(16384) && TW'(dsq) <= quo_reg)
                    begin
                        q_root_reg <= cand;
                    end
                    bit_reg <= bit_reg >> 1;
                end
            end
            ST_NEXT:
            begin
                unique case (k_reg)
                    2'd0: res_reg.qw <= s_cur[SW-1] ? -QuatW'(q_root_reg) : QuatW'(q_root_reg);
                    2'd1: res_reg.qx <= s_cur[SW-1] ? -QuatW'(q_root_reg) : QuatW'(q_root_reg);
                    2'd2: res_reg.qy <= s_cur[SW-1] ? -QuatW'(q_root_reg) : QuatW'(q_root_reg);
                    default: res_reg.qz <= s_cur[SW-1] ? -QuatW'(q_root_reg)
                                                       : QuatW'(q_root_reg);
                endcase
                k_reg       <= k_reg + 2'd1;
                num_reg     <= TW'(mag_sq_next(s_reg[k_reg + 2'd1])) << 30;
                rem_reg     <= '0;
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

### sv/pfnt_checker.sv
// Port-level checker for the pose fusion block, bound to the top level.
`default_nettype none
module pfnt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  mode,
    input wire logic [15:0] fused_qw
);
    import pfnt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode))
        else $error("result dropped while stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode == MODE_DEGEN |-> fused_qw == 16'd0)
        else $error("degenerate result with nonzero quaternion");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result present after reset");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");
endmodule

bind pose_fusion_nearest_timestamp pfnt_checker u_pfnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mode      (mode),
    .fused_qw  (fused_qw)
);
`default_nettype wire
